// ===== sv/tsvdd_pkg.sv =====
// Shared types and constants for the TSV group defect diagnosis block.
package tsvdd_pkg;

    localparam int GROUP_WIDTH  = 4;
    localparam int SIZE_W       = 3;
    localparam int LIMIT_W      = 12;
    localparam int FOUND_W      = 3;
    localparam int PROBE_W      = 2;
    localparam int SESS_W       = 3;
    localparam int DIE_CNT_W    = 16;
    localparam int TOTAL_CNT_W  = 32;
    localparam int IN_DATA_W    = 8;
    localparam int IN_USER_W    = 1;
    localparam int OUT_DATA_W   = 72;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(5);

    // Classified group: cumulative mask and defect count after each probe,
    // and the number of probes the group would take with no limit.
    typedef struct packed {
        logic                   die_start;
        logic [PROBE_W-1:0]     probes;
        logic [GROUP_WIDTH-1:0] mask1;
        logic [GROUP_WIDTH-1:0] mask2;
        logic [GROUP_WIDTH-1:0] mask3;
        logic [FOUND_W-1:0]     found1;
        logic [FOUND_W-1:0]     found2;
        logic [FOUND_W-1:0]     found3;
    } diag_item_t;

    // Result carried in the output register.
    typedef struct packed {
        logic [TOTAL_CNT_W-1:0] all_sessions;
        logic [DIE_CNT_W-1:0]   defects_found;
        logic [DIE_CNT_W-1:0]   die_sessions;
        logic [SESS_W-1:0]      group_sessions;
        logic [GROUP_WIDTH-1:0] defect_mask;
    } diag_result_t;

endpackage

// ===== sv/tsvdd_front.sv =====
// Front end: accept a group beat and work out its probe sequence.
module tsvdd_front
(
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tsvdd_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [tsvdd_pkg::IN_USER_W-1:0] s_tuser,
    input  logic                          q_ready,
    output logic                          q_push,
    output tsvdd_pkg::diag_item_t         q_item
);
    import tsvdd_pkg::*;

    logic [GROUP_WIDTH-1:0] bits;
    logic [SIZE_W-1:0]      size_raw;
    logic [1:0]             size_code;
    logic [GROUP_WIDTH-1:0] valid_mask;
    logic                   all_good;
    logic                   even;
    logic [1:0]             goods3;
    logic [GROUP_WIDTH-1:0] m1;
    logic [GROUP_WIDTH-1:0] m2;
    logic [GROUP_WIDTH-1:0] m3;
    logic [FOUND_W-1:0]     f1;
    logic [FOUND_W-1:0]     f2;
    logic [FOUND_W-1:0]     f3;
    logic [PROBE_W-1:0]     p;

    assign bits     = s_tdata[GROUP_WIDTH-1:0];
    assign size_raw = s_tdata[GROUP_WIDTH+SIZE_W-1:GROUP_WIDTH];

    // Clamp size: zero acts as one, anything above four as four.
    always_comb
    begin
        if (size_raw == SIZE_W'(0))
            size_code = 2'd0;
        else if (size_raw > SIZE_W'(GROUP_WIDTH))
            size_code = 2'd3;
        else
            size_code = 2'(size_raw - SIZE_W'(1));
    end

    always_comb
    begin
        case (size_code)
            2'd0:    valid_mask = 4'b0001;
            2'd1:    valid_mask = 4'b0011;
            2'd2:    valid_mask = 4'b0111;
            default: valid_mask = 4'b1111;
        endcase
    end

    assign all_good = &(bits | ~valid_mask);
    assign even     = ~(^(bits & valid_mask));
    assign goods3   = 2'(bits[0]) + 2'(bits[1]) + 2'(bits[3]);

    always_comb
    begin
        m1 = '0;
        m2 = '0;
        m3 = '0;
        f1 = '0;
        f2 = '0;
        f3 = '0;
        p  = '0;
        if (!all_good)
        begin
            // First probe is always the front TSV.
            m1 = {3'b000, ~bits[0]};
            f1 = FOUND_W'(!bits[0]);
            case (size_code)
                2'd0:
                begin
                    p = 2'd1;
                end
                2'd1:
                begin
                    p  = 2'd2;
                    m2 = m1 | {2'b00, ~bits[1], 1'b0};
                    f2 = f1 + FOUND_W'(!bits[1]);
                end
                2'd2:
                begin
                    if (bits[2] && bits[0] && even)
                    begin
                        // Pair inference marks the two TSVs below the back one.
                        p  = 2'd2;
                        m2 = m1 | 4'b0011;
                        f2 = f1 + FOUND_W'(2);
                    end
                    else
                    begin
                        p  = 2'd3;
                        m2 = m1 | {1'b0, ~bits[2], 2'b00};
                        f2 = f1 + FOUND_W'(!bits[2]);
                        m3 = m2 | {2'b00, ~bits[1], 1'b0};
                        f3 = f2 + FOUND_W'(!bits[1]);
                    end
                end
                default:
                begin
                    if (bits[3] && bits[0] && even)
                    begin
                        p  = 2'd2;
                        m2 = m1 | 4'b0110;
                        f2 = f1 + FOUND_W'(2);
                    end
                    else
                    begin
                        p  = 2'd3;
                        m2 = m1 | {~bits[3], 3'b000};
                        f2 = f1 + FOUND_W'(!bits[3]);
                        m3 = m2;
                        f3 = f2;
                        // Third probe hits TSV1; parity and good count infer TSV2.
                        case ({even, goods3})
                            3'b100:
                            begin
                                m3 = m2 | 4'b0110;
                                f3 = f2 + FOUND_W'(2);
                            end
                            3'b101:
                            begin
                                if (!bits[1])
                                begin
                                    m3 = m2 | 4'b0010;
                                    f3 = f2 + FOUND_W'(1);
                                end
                            end
                            3'b110:
                            begin
                                m3 = m2 | 4'b0100;
                                f3 = f2 + FOUND_W'(1);
                            end
                            3'b000:
                            begin
                                m3 = m2 | 4'b0010;
                                f3 = f2 + FOUND_W'(1);
                            end
                            3'b001:
                            begin
                                if (!bits[1])
                                begin
                                    m3 = m2 | 4'b0110;
                                    f3 = f2 + FOUND_W'(2);
                                end
                                else
                                begin
                                    m3 = m2 | 4'b0100;
                                    f3 = f2 + FOUND_W'(1);
                                end
                            end
                            3'b010:
                            begin
                                if (!bits[1])
                                begin
                                    m3 = m2 | 4'b0010;
                                    f3 = f2 + FOUND_W'(1);
                                end
                            end
                            3'b011:
                            begin
                                m3 = m2 | 4'b0100;
                                f3 = f2 + FOUND_W'(1);
                            end
                            default:
                            begin
                                m3 = m2;
                                f3 = f2;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid & q_ready;

    always_comb
    begin
        q_item.die_start = s_tuser[0];
        q_item.probes    = p;
        q_item.mask1     = m1;
        q_item.mask2     = m2;
        q_item.mask3     = m3;
        q_item.found1    = f1;
        q_item.found2    = f2;
        q_item.found3    = f3;
    end

endmodule

// ===== sv/tsvdd_queue.sv =====
// Short queue of classified groups between the front and back ends.
module tsvdd_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tsvdd_pkg::diag_item_t push_item,
    output logic                  not_full,
    input  logic                  pop,
    output logic                  not_empty,
    output tsvdd_pkg::diag_item_t pop_item
);
    import tsvdd_pkg::*;

    diag_item_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== sv/tsvdd_back.sv =====
// Back end: apply the defect limit, update the counters, hold the result.
module tsvdd_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [tsvdd_pkg::LIMIT_W-1:0]        defect_limit,
    input  logic                                 q_valid,
    input  tsvdd_pkg::diag_item_t                q_item,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output tsvdd_pkg::diag_result_t              result
);
    import tsvdd_pkg::*;

    logic [DIE_CNT_W-1:0]   die_defect_reg;
    logic [DIE_CNT_W-1:0]   die_defect_next;
    logic [DIE_CNT_W-1:0]   die_sess_reg;
    logic [DIE_CNT_W-1:0]   die_sess_next;
    logic [TOTAL_CNT_W-1:0] total_sess_reg;
    logic [TOTAL_CNT_W-1:0] total_sess_next;
    logic                   out_valid_reg;
    diag_result_t           result_reg;
    diag_result_t           result_next;

    logic [DIE_CNT_W-1:0]   defect_base;
    logic [DIE_CNT_W-1:0]   sess_base;
    logic [DIE_CNT_W-1:0]   limit_ext;
    logic [DIE_CNT_W-1:0]   c1;
    logic [DIE_CNT_W-1:0]   c2;
    logic [DIE_CNT_W-1:0]   c3;
    logic [PROBE_W-1:0]     q;
    logic [SESS_W-1:0]      sessions;
    logic [GROUP_WIDTH-1:0] mask_sel;

    function automatic logic [DIE_CNT_W-1:0] sat_die(input logic [DIE_CNT_W-1:0] a,
                                                     input logic [DIE_CNT_W-1:0] b);
        logic [DIE_CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIE_CNT_W] ? '1 : s[DIE_CNT_W-1:0];
    endfunction

    assign q_pop = q_valid & (~out_valid_reg | m_tready);

    assign defect_base = q_item.die_start ? '0 : die_defect_reg;
    assign sess_base   = q_item.die_start ? '0 : die_sess_reg;
    assign limit_ext   = DIE_CNT_W'(defect_limit);

    // Count after each probe prefix; probing halts where it equals the limit.
    assign c1 = sat_die(defect_base, DIE_CNT_W'(q_item.found1));
    assign c2 = sat_die(defect_base, DIE_CNT_W'(q_item.found2));
    assign c3 = sat_die(defect_base, DIE_CNT_W'(q_item.found3));

    always_comb
    begin
        if (q_item.probes >= PROBE_W'(1) && defect_base == limit_ext)
            q = PROBE_W'(0);
        else if (q_item.probes >= PROBE_W'(2) && c1 == limit_ext)
            q = PROBE_W'(1);
        else if (q_item.probes >= PROBE_W'(3) && c2 == limit_ext)
            q = PROBE_W'(2);
        else
            q = q_item.probes;
    end

    always_comb
    begin
        case (q)
            2'd0:
            begin
                mask_sel        = '0;
                die_defect_next = defect_base;
            end
            2'd1:
            begin
                mask_sel        = q_item.mask1;
                die_defect_next = c1;
            end
            2'd2:
            begin
                mask_sel        = q_item.mask2;
                die_defect_next = c2;
            end
            default:
            begin
                mask_sel        = q_item.mask3;
                die_defect_next = c3;
            end
        endcase
    end

    assign sessions      = SESS_W'(q) + SESS_W'(1);
    assign die_sess_next = sat_die(sess_base, DIE_CNT_W'(sessions));

    always_comb
    begin
        logic [TOTAL_CNT_W:0] s;
        s = {1'b0, total_sess_reg} + (TOTAL_CNT_W + 1)'(sessions);
        total_sess_next = s[TOTAL_CNT_W] ? '1 : s[TOTAL_CNT_W-1:0];
    end

    always_comb
    begin
        result_next.defect_mask    = mask_sel;
        result_next.group_sessions = sessions;
        result_next.die_sessions   = die_sess_next;
        result_next.defects_found  = die_defect_next;
        result_next.all_sessions   = total_sess_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            die_defect_reg <= '0;
            die_sess_reg   <= '0;
            total_sess_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                die_defect_reg <= die_defect_next;
                die_sess_reg   <= die_sess_next;
                total_sess_reg <= total_sess_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

endmodule

// ===== sv/tsv_group_defect_diagnosis_core.sv =====
// TSV group defect diagnosis: one group of up to four TSVs per beat, one result per group.
//
// Each input beat carries the pass bits of a group of up to four TSVs (1 means good)
// and its size; a group whose valid TSVs are all good costs one group test session.
// Any other group is probed one TSV at a time, alternating front and back, and the
// group parity infers the rest through a fixed table. Probing halts while the per-die
// located-defect count equals defect_limit (reset value 5, written on the cfg channel
// while the block is idle). The result reports the located-defect mask, the sessions
// spent on the group, and saturating per-die session and defect counts plus a
// saturating session total since reset. s_tuser[0] marks the first group of a die and
// clears the per-die counts before that group. The block takes one group per clock,
// while m_tready stays high: the front end classifies each group in the accept cycle
// into a two-entry queue, and the back end resolves the limit and updates the counters
// for each group into an output register. A result is offered from the output register
// once its group has passed through the queue, and the input keeps flowing while a
// result waits for m_tready until the queue fills.
module tsv_group_defect_diagnosis_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    // cfg_data: defect_limit[11:0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsvdd_pkg::LIMIT_W-1:0]     cfg_data,
    // s_tdata: group_bits[3:0], group_size[6:4], zero[7]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tsvdd_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: die_start[0]
    input  logic [tsvdd_pkg::IN_USER_W-1:0]   s_tuser,
    // m_tdata: defect_mask[3:0], group_sessions[6:4], die_sessions[22:7],
    //          defects_found[38:23], all_sessions[70:39], zero[71]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tsvdd_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import tsvdd_pkg::*;

    logic [LIMIT_W-1:0] defect_limit_reg;
    logic               q_push;
    logic               q_not_full;
    logic               q_pop;
    logic               q_not_empty;
    diag_item_t         push_item;
    diag_item_t         pop_item;
    diag_result_t       result;

    // Always ready; the user must write only while the block is idle; it is not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            defect_limit_reg <= LIMIT_RESET;
        else if (cfg_valid)
            defect_limit_reg <= cfg_data;
    end

    // Classify the incoming group; stall the input only when the queue is full.
    tsvdd_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_not_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    tsvdd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (pop_item)
    );

    // Resolve the limit, advance the counters and hold the result beat.
    tsvdd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .defect_limit (defect_limit_reg),
        .q_valid      (q_not_empty),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .result       (result)
    );

    assign m_tdata = {1'b0, result.all_sessions, result.defects_found, result.die_sessions,
                      result.group_sessions, result.defect_mask};

endmodule
